// ===== design/aob_pkg.sv =====
// ----------------------------------------------------------------------------
// aob_pkg: shared types and constants for the alpha over blend pipeline
// Widths of the blend datapath, the reciprocal used for the alpha divide by
// 255, and the word carried through the divider stages.
// ----------------------------------------------------------------------------
package aob_pkg;

  localparam int ChanW  = 8;               // unorm8 channel
  localparam int Lanes  = 3;               // red, green, blue
  localparam int ProdW  = 2 * ChanW;       // channel times alpha
  localparam int DenW   = 16;              // D, at most 65025
  localparam int NumW   = 24;              // colour numerator, below 2^24
  localparam int RemW   = NumW + 2;        // 2*num + D
  localparam int DivW   = DenW + 1;        // 2*D
  localparam int QuoW   = ChanW;           // quotient never passes 255

  localparam logic [ChanW-1:0] UnormMax  = 8'd255;
  localparam logic [ChanW-1:0] UnormZero = 8'd0;
  localparam logic [DenW-1:0]  HalfUnorm = 16'd127;

  // floor(y / 255) = (y * RecipMul) >> RecipShift for every y below 66052
  localparam logic [15:0] RecipMul   = 16'd32897;
  localparam int          RecipShift = 23;

  typedef struct packed {
    logic [ChanW-1:0] red;
    logic [ChanW-1:0] green;
    logic [ChanW-1:0] blue;
    logic [ChanW-1:0] alpha;
  } pixel_t;

  // one word in the divider section of the pipeline
  typedef struct packed {
    logic                        valid;
    logic                        pass;    // result is the stored pixel as is
    pixel_t                      pix;
    logic [ChanW-1:0]            alpha;   // blended alpha
    logic [DivW-1:0]             dv;      // 2*D
    logic [Lanes-1:0][RemW-1:0]  rem;
    logic [Lanes-1:0][QuoW-1:0]  quo;
  } div_word_t;

endpackage

// ===== design/alpha_over_blend_top.sv =====
// ----------------------------------------------------------------------------
// alpha_over_blend_top: straight-alpha Porter-Duff over composite
// Blends a foreground RGBA pixel over a background pixel, unorm8 channels,
// colour channels rounded to nearest with ties up.
// ----------------------------------------------------------------------------
// A pixel pair is taken at every clock edge with start_i high; busy_o stays
// low, so one pixel enters per clock without gaps. The composited pixel shows
// on the out_*_o ports, with valid_o high, for one cycle (throughput 1 per
// clock). The receiver cannot stall the block. The latency is set by three
// multiply and add stages followed by an 8-stage restoring divider, one
// quotient bit per stage, and the output register. Opaque foreground passes
// the foreground through, transparent foreground the background, with the
// same latency.
module alpha_over_blend_top (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       start_i,
  output logic       busy_o,
  input  logic [7:0] fg_red_i,
  input  logic [7:0] fg_green_i,
  input  logic [7:0] fg_blue_i,
  input  logic [7:0] fg_alpha_i,
  input  logic [7:0] bg_red_i,
  input  logic [7:0] bg_green_i,
  input  logic [7:0] bg_blue_i,
  input  logic [7:0] bg_alpha_i,
  output logic       valid_o,
  output logic [7:0] out_red_o,
  output logic [7:0] out_green_o,
  output logic [7:0] out_blue_o,
  output logic [7:0] out_alpha_o
);

  localparam int ChanW = aob_pkg::ChanW;
  localparam int Lanes = aob_pkg::Lanes;
  localparam int ProdW = aob_pkg::ProdW;
  localparam int DenW  = aob_pkg::DenW;
  localparam int NumW  = aob_pkg::NumW;
  localparam int RemW  = aob_pkg::RemW;
  localparam int DivW  = aob_pkg::DivW;
  localparam int QuoW  = aob_pkg::QuoW;

  assign busy_o = 1'b0;

  // --------------------------------------------------------------------------
  // Stage 1: products of channel and alpha, D
  // --------------------------------------------------------------------------
  logic [Lanes-1:0][ChanW-1:0] fg_c, bg_c;
  assign fg_c = {fg_blue_i, fg_green_i, fg_red_i};
  assign bg_c = {bg_blue_i, bg_green_i, bg_red_i};

  logic                        v1_q;
  logic                        pass1_q, pass1_d;
  aob_pkg::pixel_t             pix1_q, pix1_d;
  logic [ChanW-1:0]            inv1_q, inv1_d;
  logic [DenW-1:0]             d1_q, d1_d;
  logic [Lanes-1:0][ProdW-1:0] pf1_q, pf1_d, pb1_q, pb1_d;

  always_comb begin
    inv1_d  = aob_pkg::UnormMax - fg_alpha_i;
    pass1_d = (fg_alpha_i == aob_pkg::UnormMax) || (fg_alpha_i == aob_pkg::UnormZero);
    if (fg_alpha_i == aob_pkg::UnormMax) begin
      pix1_d = '{red: fg_red_i, green: fg_green_i, blue: fg_blue_i, alpha: fg_alpha_i};
    end else begin
      pix1_d = '{red: bg_red_i, green: bg_green_i, blue: bg_blue_i, alpha: bg_alpha_i};
    end
    // D = 255*fa + ba*(255-fa)
    d1_d = ({fg_alpha_i, {ChanW{1'b0}}} - {{(DenW-ChanW){1'b0}}, fg_alpha_i})
         + DenW'(bg_alpha_i * inv1_d);
    for (int c = 0; c < Lanes; c++) begin
      pf1_d[c] = ProdW'(fg_c[c] * fg_alpha_i);
      pb1_d[c] = ProdW'(bg_c[c] * bg_alpha_i);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else begin
      v1_q <= start_i;
    end
  end

  always_ff @(posedge clk_i) begin
    pass1_q <= pass1_d;
    pix1_q  <= pix1_d;
    inv1_q  <= inv1_d;
    d1_q    <= d1_d;
    pf1_q   <= pf1_d;
    pb1_q   <= pb1_d;
  end

  // --------------------------------------------------------------------------
  // Stage 2: numerator terms, blended alpha
  // --------------------------------------------------------------------------
  logic                       v2_q;
  logic                       pass2_q;
  aob_pkg::pixel_t            pix2_q;
  logic [DenW-1:0]            d2_q;
  logic [ChanW-1:0]           alpha2_q, alpha2_d;
  logic [Lanes-1:0][NumW-1:0] numf2_q, numf2_d, numb2_q, numb2_d;
  logic [DenW-1:0]            a_round;
  logic [31:0]                a_prod;

  always_comb begin
    a_round  = d1_q + aob_pkg::HalfUnorm;
    a_prod   = a_round * aob_pkg::RecipMul;
    alpha2_d = a_prod[aob_pkg::RecipShift +: ChanW];
    for (int c = 0; c < Lanes; c++) begin
      // times 255 as a shift and subtract
      numf2_d[c] = {pf1_q[c], {ChanW{1'b0}}} - {{(NumW-ProdW){1'b0}}, pf1_q[c]};
      numb2_d[c] = NumW'(pb1_q[c] * inv1_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
    end else begin
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    pass2_q  <= pass1_q;
    pix2_q   <= pix1_q;
    d2_q     <= d1_q;
    alpha2_q <= alpha2_d;
    numf2_q  <= numf2_d;
    numb2_q  <= numb2_d;
  end

  // --------------------------------------------------------------------------
  // Stage 3 and divider: round(num / D) = floor((2*num + D) / (2*D))
  // --------------------------------------------------------------------------
  aob_pkg::div_word_t div_q [QuoW+1];
  aob_pkg::div_word_t div_d [QuoW+1];

  always_comb begin
    div_d[0].valid = v2_q;
    div_d[0].pass  = pass2_q;
    div_d[0].pix   = pix2_q;
    div_d[0].alpha = alpha2_q;
    div_d[0].dv    = {d2_q, 1'b0};
    div_d[0].quo   = '0;
    for (int c = 0; c < Lanes; c++) begin
      div_d[0].rem[c] = {numf2_q[c] + numb2_q[c], 1'b0}
                      + {{(RemW-DenW){1'b0}}, d2_q};
    end
  end

  for (genvar j = 0; j < QuoW; j++) begin : g_div
    localparam int Sh = QuoW - 1 - j;
    logic [RemW-1:0] sub;
    assign sub = {{(RemW-DivW){1'b0}}, div_q[j].dv} << Sh;

    always_comb begin
      div_d[j+1] = div_q[j];
      for (int c = 0; c < Lanes; c++) begin
        if (div_q[j].rem[c] >= sub) begin
          div_d[j+1].rem[c] = div_q[j].rem[c] - sub;
          div_d[j+1].quo[c] = {div_q[j].quo[c][QuoW-2:0], 1'b1};
        end else begin
          div_d[j+1].quo[c] = {div_q[j].quo[c][QuoW-2:0], 1'b0};
        end
      end
    end
  end

  for (genvar j = 0; j <= QuoW; j++) begin : g_div_reg
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        div_q[j] <= '0;
      end else begin
        div_q[j] <= div_d[j];
      end
    end
  end

  // --------------------------------------------------------------------------
  // Output register: pick pass-through or blended word
  // --------------------------------------------------------------------------
  logic            out_v_q;
  aob_pkg::pixel_t out_q, out_d;

  always_comb begin
    if (div_q[QuoW].pass) begin
      out_d = div_q[QuoW].pix;
    end else begin
      out_d = '{red:   div_q[QuoW].quo[0],
                green: div_q[QuoW].quo[1],
                blue:  div_q[QuoW].quo[2],
                alpha: div_q[QuoW].alpha};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else begin
      out_v_q <= div_q[QuoW].valid;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign valid_o     = out_v_q;
  assign out_red_o   = out_q.red;
  assign out_green_o = out_q.green;
  assign out_blue_o  = out_q.blue;
  assign out_alpha_o = out_q.alpha;

endmodule
